### hw/rtl/assembly_source_tokenizer_assert.svh
// assertion macros for the tokenizer rtl (used by assembly_source_tokenizer)
// expects clk and arst_n in the scope of each use
`ifndef ASSEMBLY_SOURCE_TOKENIZER_ASSERT_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_ASSERT_SVH

// same-cycle implication, off during reset
`define AST_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define AST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ast_pkg.sv
// types, character codes and helper functions for the tokenizer
// no dependencies; used by ast_lexer and assembly_source_tokenizer
package ast_pkg;

	typedef enum logic [3:0] {
		M_SKIP    = 4'd0,
		M_COMMENT = 4'd1,
		M_SYMBOL  = 4'd2,
		M_BIN     = 4'd3,
		M_OCT     = 4'd4,
		M_DEC     = 4'd5,
		M_HEX     = 4'd6,
		M_QUOTE   = 4'd7,
		M_DOT     = 4'd8,
		M_ZERO    = 4'd9
	} mode_t;

	typedef enum logic [3:0] {
		T_NEWLINE = 4'd0,
		T_DOT     = 4'd1,
		T_COMMA   = 4'd2,
		T_OPEN    = 4'd3,
		T_CLOSE   = 4'd4,
		T_MINUS   = 4'd5,
		T_LABEL   = 4'd6,
		T_SYMBOL  = 4'd7,
		T_IMM     = 4'd8,
		T_CHAR    = 4'd9,
		T_END     = 4'd10
	} token_t;

	localparam logic KIND_TEXT  = 1'b0;
	localparam logic KIND_TOKEN = 1'b1;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	// digit value code meaning "not a hex digit"
	localparam logic [4:0] DIGIT_NONE = 5'd16;

	typedef struct packed {
		logic        kind;
		token_t      tok;
		logic [7:0]  text;
		logic [31:0] imm;
		logic        bad;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} lex_res_t;

	typedef struct packed {
		result_t r;
		logic    last;
	} out_item_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic [4:0] digit_val(input logic [7:0] c);
		logic [4:0] v;
		if (is_digit(c)) begin
			v = {1'b0, c[3:0]};
		end else if (c >= CH_LA && c <= CH_LF) begin
			v = 5'(c - CH_LA) + 5'd10;
		end else if (c >= CH_UA && c <= CH_UF) begin
			v = 5'(c - CH_UA) + 5'd10;
		end else begin
			v = DIGIT_NONE;
		end
		return v;
	endfunction

	function automatic result_t make_result(input logic kind, input token_t tok,
			input logic [7:0] text, input logic [31:0] imm, input logic bad);
		result_t r;
		r.kind = kind;
		r.tok  = tok;
		r.text = text;
		r.imm  = imm;
		r.bad  = bad;
		return r;
	endfunction

endpackage

### hw/rtl/ast_lexer.sv
// lexer state (mode, accumulator, digit flag) and the per-byte decode
// depends on ast_pkg; instantiated by assembly_source_tokenizer
module ast_lexer #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        char_code,
	input  logic              end_of_text,
	output ast_pkg::lex_res_t res
);

	localparam int IMM_COPY = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

	ast_pkg::mode_t mode_q, nmode;
	logic [VALUE_WIDTH-1:0] acc_q, nacc, mul_acc, digit_acc;
	logic seen_q, nseen;
	logic [31:0] acc_imm;
	logic [4:0] dval;
	logic base_ok;

	// skip-mode decode of the current byte
	ast_pkg::mode_t sk_mode;
	logic sk_valid, sk_dec;
	ast_pkg::result_t sk_res;

	logic out0_v, out1_v, do_skip;
	ast_pkg::result_t out0, out1;
	logic [VALUE_WIDTH-1:0] base_acc;
	logic base_seen;

	generate
		if (VALUE_WIDTH < 32) begin : g_imm_ext
			assign acc_imm = {{(32 - VALUE_WIDTH){1'b0}}, acc_q};
		end else begin : g_imm_cut
			assign acc_imm = acc_q[IMM_COPY-1:0];
		end
	endgenerate

	assign dval      = ast_pkg::digit_val(char_code);
	assign digit_acc = VALUE_WIDTH'(dval[3:0]);

	always_comb begin
		case (mode_q)
			ast_pkg::M_BIN: begin
				mul_acc = acc_q << 1;
				base_ok = dval < 5'd2;
			end
			ast_pkg::M_OCT: begin
				mul_acc = acc_q << 3;
				base_ok = dval < 5'd8;
			end
			ast_pkg::M_DEC: begin
				mul_acc = (acc_q << 3) + (acc_q << 1);
				base_ok = dval < 5'd10;
			end
			default: begin
				mul_acc = acc_q << 4;
				base_ok = dval != ast_pkg::DIGIT_NONE;
			end
		endcase
	end

	always_comb begin
		sk_valid = 1'b0;
		sk_dec   = 1'b0;
		sk_mode  = ast_pkg::M_SKIP;
		sk_res   = ast_pkg::make_result(ast_pkg::KIND_TOKEN, ast_pkg::T_NEWLINE,
			8'd0, 32'd0, 1'b0);
		case (char_code)
			ast_pkg::CH_SEMI:  sk_mode = ast_pkg::M_COMMENT;
			ast_pkg::CH_QUOTE: sk_mode = ast_pkg::M_QUOTE;
			ast_pkg::CH_DOT:   sk_mode = ast_pkg::M_DOT;
			ast_pkg::CH_ZERO:  sk_mode = ast_pkg::M_ZERO;
			ast_pkg::CH_NL:    sk_valid = 1'b1;
			ast_pkg::CH_COMMA: begin
				sk_valid   = 1'b1;
				sk_res.tok = ast_pkg::T_COMMA;
			end
			ast_pkg::CH_OPEN: begin
				sk_valid   = 1'b1;
				sk_res.tok = ast_pkg::T_OPEN;
			end
			ast_pkg::CH_CLOSE: begin
				sk_valid   = 1'b1;
				sk_res.tok = ast_pkg::T_CLOSE;
			end
			ast_pkg::CH_MINUS: begin
				sk_valid   = 1'b1;
				sk_res.tok = ast_pkg::T_MINUS;
			end
			default: begin
				if (ast_pkg::is_digit(char_code)) begin
					sk_mode = ast_pkg::M_DEC;
					sk_dec  = 1'b1;
				end else if (ast_pkg::is_alpha(char_code) || char_code == ast_pkg::CH_UNDER) begin
					sk_mode  = ast_pkg::M_SYMBOL;
					sk_valid = 1'b1;
					sk_res   = ast_pkg::make_result(ast_pkg::KIND_TEXT, ast_pkg::T_SYMBOL,
						char_code, 32'd0, 1'b0);
				end
			end
		endcase
	end

	always_comb begin
		nmode     = mode_q;
		nacc      = acc_q;
		nseen     = seen_q;
		base_acc  = acc_q;
		base_seen = seen_q;
		do_skip   = 1'b0;
		out0_v    = 1'b0;
		out1_v    = 1'b0;
		out0      = ast_pkg::make_result(ast_pkg::KIND_TOKEN, ast_pkg::T_END,
			8'd0, 32'd0, 1'b0);
		out1      = out0;

		if (end_of_text) begin
			// flush whatever is pending, then the end token
			out1_v = 1'b1;
			out0_v = 1'b1;
			case (mode_q)
				ast_pkg::M_SYMBOL: out0.tok = ast_pkg::T_SYMBOL;
				ast_pkg::M_QUOTE:  out0.tok = ast_pkg::T_CHAR;
				ast_pkg::M_DOT:    out0.tok = ast_pkg::T_DOT;
				ast_pkg::M_ZERO:   out0.tok = ast_pkg::T_IMM;
				ast_pkg::M_BIN, ast_pkg::M_OCT, ast_pkg::M_DEC, ast_pkg::M_HEX: begin
					out0.tok = ast_pkg::T_IMM;
					out0.imm = acc_imm;
					out0.bad = !seen_q;
				end
				default: begin
					out0_v = 1'b0;
					out1_v = 1'b0;
					out0_v = 1'b1;
				end
			endcase
			if (!(mode_q == ast_pkg::M_SYMBOL || mode_q == ast_pkg::M_QUOTE ||
					mode_q == ast_pkg::M_DOT || mode_q == ast_pkg::M_ZERO ||
					mode_q == ast_pkg::M_BIN || mode_q == ast_pkg::M_OCT ||
					mode_q == ast_pkg::M_DEC || mode_q == ast_pkg::M_HEX)) begin
				out1_v = 1'b0;
			end
			nmode = ast_pkg::M_SKIP;
			nacc  = '0;
			nseen = 1'b0;
		end else begin
			case (mode_q)
				ast_pkg::M_COMMENT: begin
					do_skip = char_code == ast_pkg::CH_NL;
				end
				ast_pkg::M_SYMBOL: begin
					if (ast_pkg::is_alpha(char_code) || ast_pkg::is_digit(char_code) ||
							char_code == ast_pkg::CH_UNDER) begin
						out0_v = 1'b1;
						out0   = ast_pkg::make_result(ast_pkg::KIND_TEXT, ast_pkg::T_SYMBOL,
							char_code, 32'd0, 1'b0);
					end else if (char_code == ast_pkg::CH_COLON) begin
						out0_v   = 1'b1;
						out0.tok = ast_pkg::T_LABEL;
						nmode    = ast_pkg::M_SKIP;
					end else begin
						out0_v   = 1'b1;
						out0.tok = ast_pkg::T_SYMBOL;
						do_skip  = 1'b1;
					end
				end
				ast_pkg::M_BIN, ast_pkg::M_OCT, ast_pkg::M_DEC, ast_pkg::M_HEX: begin
					if (base_ok) begin
						nacc  = mul_acc + digit_acc;
						nseen = 1'b1;
					end else begin
						out0_v    = 1'b1;
						out0.tok  = ast_pkg::T_IMM;
						out0.imm  = acc_imm;
						out0.bad  = !seen_q;
						base_acc  = '0;
						base_seen = 1'b0;
						do_skip   = 1'b1;
					end
				end
				ast_pkg::M_QUOTE: begin
					out0_v = 1'b1;
					if (char_code == ast_pkg::CH_QUOTE) begin
						out0.tok = ast_pkg::T_CHAR;
						nmode    = ast_pkg::M_SKIP;
					end else begin
						out0 = ast_pkg::make_result(ast_pkg::KIND_TEXT, ast_pkg::T_CHAR,
							char_code, 32'd0, 1'b0);
					end
				end
				ast_pkg::M_DOT: begin
					if (ast_pkg::is_alpha(char_code)) begin
						out0_v = 1'b1;
						out1_v = 1'b1;
						out0   = ast_pkg::make_result(ast_pkg::KIND_TEXT, ast_pkg::T_SYMBOL,
							ast_pkg::CH_DOT, 32'd0, 1'b0);
						out1   = ast_pkg::make_result(ast_pkg::KIND_TEXT, ast_pkg::T_SYMBOL,
							char_code, 32'd0, 1'b0);
						nmode  = ast_pkg::M_SYMBOL;
					end else begin
						out0_v   = 1'b1;
						out0.tok = ast_pkg::T_DOT;
						do_skip  = 1'b1;
					end
				end
				ast_pkg::M_ZERO: begin
					if (char_code == ast_pkg::CH_B) begin
						nmode = ast_pkg::M_BIN;
						nacc  = '0;
						nseen = 1'b0;
					end else if (char_code == ast_pkg::CH_X) begin
						nmode = ast_pkg::M_HEX;
						nacc  = '0;
						nseen = 1'b0;
					end else if (char_code >= ast_pkg::CH_ZERO && char_code <= ast_pkg::CH_SEVEN) begin
						nmode = ast_pkg::M_OCT;
						nacc  = digit_acc;
						nseen = 1'b1;
					end else begin
						// lone zero: immediate 0, byte goes back to skip decode
						out0_v    = 1'b1;
						out0.tok  = ast_pkg::T_IMM;
						base_acc  = '0;
						base_seen = 1'b0;
						do_skip   = 1'b1;
					end
				end
				default: begin
					do_skip = 1'b1;
				end
			endcase

			if (do_skip) begin
				nmode = sk_mode;
				nacc  = sk_dec ? digit_acc : base_acc;
				nseen = sk_dec | base_seen;
				if (sk_valid) begin
					if (out0_v) begin
						out1_v = 1'b1;
						out1   = sk_res;
					end else begin
						out0_v = 1'b1;
						out0   = sk_res;
					end
				end
			end
		end

		res.r0    = out0;
		res.r1    = out1;
		res.count = {1'b0, out0_v} + {1'b0, out1_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ast_pkg::M_SKIP;
			acc_q  <= '0;
			seen_q <= 1'b0;
		end else if (step) begin
			mode_q <= nmode;
			acc_q  <= nacc;
			seen_q <= nseen;
		end
	end

endmodule

### hw/rtl/assembly_source_tokenizer.sv
// tokenizer top: input register, ast_lexer, two-entry result buffer
// depends on ast_pkg, ast_lexer and assembly_source_tokenizer_assert.svh
//
// channel  dir  tdata                                        tuser        tlast
// s_       in   [7:0] char_code                              end_of_text  -
// m_       out  [3:0] token_type [11:4] text_char            item_kind    last_of_run
//               [43:12] immediate_value [44] bad_number
//
// one byte per cycle while the result buffer has room: an item is held in the input register,
// then its zero, one or two results drop into the two-entry result buffer
// an item with two results waits in the input register while the buffer still holds an
// earlier beat, as the buffer sends one beat per cycle while the receiver is ready
// an input beat passes the input register and then the result buffer before its first result beat shows
// reset puts the lexer in skip mode with a cleared accumulator and empties
// both the input register and the result buffer
`include "assembly_source_tokenizer_assert.svh"

module assembly_source_tokenizer #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tuser,   // [0] end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [3:0] token_type, [11:4] text_char,
	                               // [43:12] immediate_value, [44] bad_number
	output logic        m_tuser,   // [0] item_kind
	output logic        m_tlast    // last_of_run
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eot_s1;

	ast_pkg::lex_res_t lx;
	ast_pkg::out_item_t slot0_q, slot1_q, p0, p1, head_after;
	logic [1:0] cnt_q, cnt_after, free_slots;
	logic pop, consume, s_accept;

	ast_lexer #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (consume),
		.char_code  (char_s1),
		.end_of_text(eot_s1),
		.res        (lx)
	);

	assign pop        = m_tvalid && m_tready;
	assign cnt_after  = cnt_q - {1'b0, pop};
	assign free_slots = 2'd2 - cnt_after;
	assign consume    = valid_s1 && (lx.count <= free_slots);
	assign s_tready   = !valid_s1 || consume;
	assign s_accept   = s_tvalid && s_tready;

	assign p0.r       = lx.r0;
	assign p0.last    = lx.count == 2'd1;
	assign p1.r       = lx.r1;
	assign p1.last    = 1'b1;
	assign head_after = pop ? slot1_q : slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			char_s1 <= s_tdata;
			eot_s1  <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_after + (consume ? lx.count : 2'd0);
		end
	end

	// buffer shifts on pop, new beats land behind whatever is left
	always_ff @(posedge clk) begin
		case (cnt_after)
			2'd0: begin
				slot0_q <= p0;
				slot1_q <= p1;
			end
			2'd1: begin
				slot0_q <= head_after;
				slot1_q <= p0;
			end
			default: begin
				slot0_q <= slot0_q;
				slot1_q <= slot1_q;
			end
		endcase
	end

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = {3'b000, slot0_q.r.bad, slot0_q.r.imm, slot0_q.r.text, slot0_q.r.tok};
	assign m_tuser  = slot0_q.r.kind;
	assign m_tlast  = slot0_q.last;

	`AST_ASSERT_NEXT(a_hold_s1, valid_s1 && !consume, valid_s1 && $stable(char_s1) && $stable(eot_s1), "stalled input item changed")
	`AST_ASSERT_IMPL(a_no_overfill, cnt_q == 2'd2 && !pop, !consume || lx.count == 2'd0, "item consumed into a full buffer")
	`AST_ASSERT_NEXT(a_results_show, consume && lx.count != 2'd0, m_tvalid, "consumed results not presented")
	`AST_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q != 2'd3, "result buffer count out of range")

endmodule

### verif/tb.sv
// testbench for assembly_source_tokenizer: directed table, then random source text
// depends on ast_pkg and the tokenizer rtl; results checked against the table or a built-in lexer model
`timescale 1ns / 1ps

module tb;
	import ast_pkg::*;

	localparam int          ITEM_TARGET = 1450;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam logic [7:0]  CH_SPACE    = 8'h20;
	localparam int          MAX_REPORTS = 40;

	typedef struct packed {
		logic        kind;
		token_t      tok;
		logic [7:0]  text;
		logic [31:0] imm;
		logic        bad;
		logic        last;
	} tok_res_t;

	// nexp < 0: expectation comes from the lexer model
	typedef struct {
		logic [7:0] c;
		logic       eot;
		int         nexp;
		tok_res_t   r0;
		tok_res_t   r1;
	} beat_plan_t;

	localparam tok_res_t NO_RES = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	beat_plan_t  plan_q[$];
	tok_res_t    token_expect_q[$];
	beat_plan_t  dir_rows[25];
	int          fail_count = 0;
	int          sent_beats = 0;
	int unsigned cycle_count = 0;
	int          stall_left = 0;
	bit          gaps_on = 1'b1;
	bit          stalls_on = 1'b1;

	// lexer model state
	mode_t       lx_mode = M_SKIP;
	logic [31:0] lx_acc = '0;
	logic        lx_seen = 1'b0;
	tok_res_t    lx_out[$];

	always #1 clk = ~clk;

	assembly_source_tokenizer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	function automatic logic letter_byte(input logic [7:0] c);
		return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
	endfunction

	function automatic logic decimal_byte(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// digit value of c in base, -1 when it is not one
	function automatic int base_digit(input logic [7:0] c, input int base);
		int v;
		v = -1;
		if (decimal_byte(c)) begin
			v = int'(c - CH_ZERO);
		end else if (c >= CH_LA && c <= CH_LF) begin
			v = int'(c - CH_LA) + 10;
		end else if (c >= CH_UA && c <= CH_UF) begin
			v = int'(c - CH_UA) + 10;
		end
		if (v >= base) begin
			v = -1;
		end
		return v;
	endfunction

	function automatic tok_res_t tk(input token_t t);
		tok_res_t r;
		r = '0;
		r.kind = KIND_TOKEN;
		r.tok = t;
		return r;
	endfunction

	function automatic tok_res_t tx(input token_t t, input logic [7:0] ch);
		tok_res_t r;
		r = '0;
		r.kind = KIND_TEXT;
		r.tok = t;
		r.text = ch;
		return r;
	endfunction

	function automatic tok_res_t im(input logic [31:0] v, input logic bad);
		tok_res_t r;
		r = tk(T_IMM);
		r.imm = v;
		r.bad = bad;
		return r;
	endfunction

	function automatic beat_plan_t row(input logic [7:0] c, input logic eot, input int n,
			input tok_res_t a, input tok_res_t b);
		beat_plan_t p;
		p.c = c;
		p.eot = eot;
		p.nexp = n;
		p.r0 = a;
		p.r1 = b;
		if (n == 1) begin
			p.r0.last = 1'b1;
		end else if (n == 2) begin
			p.r1.last = 1'b1;
		end
		return p;
	endfunction

	function void lx_push(input logic kind, input token_t t, input logic [7:0] text,
			input logic [31:0] imm, input logic bad);
		tok_res_t r;
		if (lx_out.size() < 2) begin
			r.kind = kind;
			r.tok = t;
			r.text = text;
			r.imm = imm;
			r.bad = bad;
			r.last = 1'b0;
			lx_out.push_back(r);
		end
	endfunction

	function void lx_number_done();
		lx_push(KIND_TOKEN, T_IMM, 8'h00, lx_acc, !lx_seen);
		lx_mode = M_SKIP;
		lx_acc = '0;
		lx_seen = 1'b0;
	endfunction

	function void lx_skip(input logic [7:0] c);
		case (c)
			CH_SEMI:  lx_mode = M_COMMENT;
			CH_QUOTE: lx_mode = M_QUOTE;
			CH_NL:    lx_push(KIND_TOKEN, T_NEWLINE, 8'h00, '0, 1'b0);
			CH_DOT:   lx_mode = M_DOT;
			CH_COMMA: lx_push(KIND_TOKEN, T_COMMA, 8'h00, '0, 1'b0);
			CH_OPEN:  lx_push(KIND_TOKEN, T_OPEN, 8'h00, '0, 1'b0);
			CH_CLOSE: lx_push(KIND_TOKEN, T_CLOSE, 8'h00, '0, 1'b0);
			CH_MINUS: lx_push(KIND_TOKEN, T_MINUS, 8'h00, '0, 1'b0);
			CH_ZERO:  lx_mode = M_ZERO;
			default: begin
				if (decimal_byte(c)) begin
					lx_mode = M_DEC;
					lx_acc = 32'(c - CH_ZERO);
					lx_seen = 1'b1;
				end else if (letter_byte(c) || c == CH_UNDER) begin
					lx_mode = M_SYMBOL;
					lx_push(KIND_TEXT, T_SYMBOL, c, '0, 1'b0);
				end
			end
		endcase
	endfunction

	function void lx_num(input logic [7:0] c, input int base);
		int d;
		d = base_digit(c, base);
		if (d >= 0) begin
			lx_acc = 32'(lx_acc * base + d);
			lx_seen = 1'b1;
		end else begin
			lx_number_done();
			lx_skip(c);
		end
	endfunction

	function void lx_byte(input logic [7:0] c);
		case (lx_mode)
			M_COMMENT: begin
				if (c == CH_NL) begin
					lx_mode = M_SKIP;
					lx_skip(c);
				end
			end
			M_SYMBOL: begin
				if (letter_byte(c) || decimal_byte(c) || c == CH_UNDER) begin
					lx_push(KIND_TEXT, T_SYMBOL, c, '0, 1'b0);
				end else if (c == CH_COLON) begin
					lx_push(KIND_TOKEN, T_LABEL, 8'h00, '0, 1'b0);
					lx_mode = M_SKIP;
				end else begin
					lx_push(KIND_TOKEN, T_SYMBOL, 8'h00, '0, 1'b0);
					lx_mode = M_SKIP;
					lx_skip(c);
				end
			end
			M_BIN: lx_num(c, 2);
			M_OCT: lx_num(c, 8);
			M_DEC: lx_num(c, 10);
			M_HEX: lx_num(c, 16);
			M_QUOTE: begin
				if (c == CH_QUOTE) begin
					lx_push(KIND_TOKEN, T_CHAR, 8'h00, '0, 1'b0);
					lx_mode = M_SKIP;
				end else begin
					lx_push(KIND_TEXT, T_CHAR, c, '0, 1'b0);
				end
			end
			M_DOT: begin
				if (letter_byte(c)) begin
					lx_push(KIND_TEXT, T_SYMBOL, CH_DOT, '0, 1'b0);
					lx_push(KIND_TEXT, T_SYMBOL, c, '0, 1'b0);
					lx_mode = M_SYMBOL;
				end else begin
					lx_push(KIND_TOKEN, T_DOT, 8'h00, '0, 1'b0);
					lx_mode = M_SKIP;
					lx_skip(c);
				end
			end
			M_ZERO: begin
				lx_acc = '0;
				if (c == CH_B) begin
					lx_mode = M_BIN;
					lx_seen = 1'b0;
				end else if (c == CH_X) begin
					lx_mode = M_HEX;
					lx_seen = 1'b0;
				end else begin
					// a lone leading zero is an octal number already holding a digit
					lx_mode = M_OCT;
					lx_seen = 1'b1;
					lx_num(c, 8);
				end
			end
			default: begin
				lx_mode = M_SKIP;
				lx_skip(c);
			end
		endcase
	endfunction

	function void lx_end();
		case (lx_mode)
			M_SYMBOL: lx_push(KIND_TOKEN, T_SYMBOL, 8'h00, '0, 1'b0);
			M_QUOTE:  lx_push(KIND_TOKEN, T_CHAR, 8'h00, '0, 1'b0);
			M_DOT:    lx_push(KIND_TOKEN, T_DOT, 8'h00, '0, 1'b0);
			M_ZERO:   lx_push(KIND_TOKEN, T_IMM, 8'h00, '0, 1'b0);
			M_BIN, M_OCT, M_DEC, M_HEX: lx_number_done();
			default: ;
		endcase
		lx_mode = M_SKIP;
		lx_acc = '0;
		lx_seen = 1'b0;
		lx_push(KIND_TOKEN, T_END, 8'h00, '0, 1'b0);
	endfunction

	// runs one accepted beat through the model
	function void lx_step(input logic [7:0] c, input logic eot);
		lx_out.delete();
		if (eot) begin
			lx_end();
		end else begin
			lx_byte(c);
		end
		if (lx_out.size() > 0) begin
			lx_out[lx_out.size() - 1].last = 1'b1;
		end
	endfunction

	function void field_bad(input string name, input logic [31:0] want, input logic [31:0] got);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$error("%s expected 0x%0h got 0x%0h", name, want, got);
		end
	endfunction

	// input beats feed the model, output beats are checked, receiver stalls are drawn
	always @(posedge clk) begin : monitor
		beat_plan_t pr;
		tok_res_t e;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pr = plan_q.pop_front();
				lx_step(s_tdata, s_tuser);
				sent_beats++;
				if (pr.nexp < 0) begin
					foreach (lx_out[i]) begin
						token_expect_q.push_back(lx_out[i]);
					end
				end else begin
					if (pr.nexp > 0) begin
						token_expect_q.push_back(pr.r0);
					end
					if (pr.nexp > 1) begin
						token_expect_q.push_back(pr.r1);
					end
				end
			end
			if (m_tvalid && m_tready) begin
				if (token_expect_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$error("result beat with no expectation: tdata 0x%0h", m_tdata);
					end
				end else begin
					e = token_expect_q.pop_front();
					if (m_tuser !== e.kind)
						field_bad("item_kind", 32'(e.kind), 32'(m_tuser));
					if (m_tdata[3:0] !== e.tok)
						field_bad("token_type", 32'(e.tok), 32'(m_tdata[3:0]));
					if (m_tdata[11:4] !== e.text)
						field_bad("text_char", 32'(e.text), 32'(m_tdata[11:4]));
					if (m_tdata[43:12] !== e.imm)
						field_bad("immediate_value", e.imm, m_tdata[43:12]);
					if (m_tdata[44] !== e.bad)
						field_bad("bad_number", 32'(e.bad), 32'(m_tdata[44]));
					if (m_tdata[47:45] !== 3'b000)
						field_bad("tdata_pad", 32'd0, 32'(m_tdata[47:45]));
					if (m_tlast !== e.last)
						field_bad("last_of_run", 32'(e.last), 32'(m_tlast));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 39)
				                                          : $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 65) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic drive_beat(input beat_plan_t b);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		plan_q.push_back(b);
		s_tvalid <= 1'b1;
		s_tdata <= b.c;
		s_tuser <= b.eot;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] c);
		drive_beat(row(c, 1'b0, -1, NO_RES, NO_RES));
	endtask

	// hold off input until every pending result has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (plan_q.size() != 0 || token_expect_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] rnd_letter();
		if ($urandom_range(0, 1) == 0) begin
			return 8'(CH_LA + $urandom_range(0, 25));
		end
		return 8'(CH_UA + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rnd_hex_digit();
		int r;
		r = $urandom_range(0, 15);
		if (r < 10) begin
			return 8'(CH_ZERO + r);
		end
		return ($urandom_range(0, 1) == 0) ? 8'(CH_LA + r - 10) : 8'(CH_UA + r - 10);
	endfunction

	// one piece of source text: mostly well-formed tokens, some noise
	task automatic gen_piece();
		int kind;
		int n;
		int r;
		logic [7:0] c;
		logic [7:0] punct[7];
		punct = '{CH_NL, CH_COMMA, CH_OPEN, CH_CLOSE, CH_MINUS, CH_SPACE, CH_DOT};
		kind = $urandom_range(0, 99);
		if (kind < 20) begin
			if ($urandom_range(0, 4) == 0) send_byte(CH_DOT);
			send_byte(($urandom_range(0, 5) == 0) ? CH_UNDER : rnd_letter());
			n = $urandom_range(0, 7);
			repeat (n) begin
				r = $urandom_range(0, 9);
				if (r < 6) send_byte(rnd_letter());
				else if (r < 9) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
				else send_byte(CH_UNDER);
			end
			if ($urandom_range(0, 2) == 0) send_byte(CH_COLON);
		end else if (kind < 35) begin
			send_byte(8'(CH_ZERO + $urandom_range(1, 9)));
			// long runs wrap the 32-bit value
			n = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(8, 14);
			repeat (n) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
		end else if (kind < 45) begin
			send_byte(CH_ZERO);
			send_byte(CH_X);
			n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
			repeat (n) send_byte(rnd_hex_digit());
		end else if (kind < 52) begin
			send_byte(CH_ZERO);
			send_byte(CH_B);
			n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
			repeat (n) send_byte(8'(CH_ZERO + $urandom_range(0, 1)));
		end else if (kind < 58) begin
			send_byte(CH_ZERO);
			n = $urandom_range(0, 12);
			repeat (n) begin
				if ($urandom_range(0, 5) == 0) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
				else send_byte(8'(CH_ZERO + $urandom_range(0, 7)));
			end
		end else if (kind < 65) begin
			send_byte(CH_QUOTE);
			n = $urandom_range(0, 3);
			repeat (n) begin
				c = 8'($urandom_range(0, 255));
				while (c == CH_QUOTE) c = 8'($urandom_range(0, 255));
				send_byte(c);
			end
			if ($urandom_range(0, 9) != 0) send_byte(CH_QUOTE);
		end else if (kind < 72) begin
			send_byte(CH_SEMI);
			n = $urandom_range(0, 10);
			repeat (n) send_byte(8'($urandom_range(0, 255)));
			send_byte(CH_NL);
		end else if (kind < 86) begin
			send_byte(punct[$urandom_range(0, 6)]);
		end else if (kind < 96) begin
			n = $urandom_range(1, 4);
			repeat (n) send_byte(8'($urandom_range(0, 255)));
		end else begin
			drive_beat(row(8'($urandom_range(0, 255)), 1'b1, -1, NO_RES, NO_RES));
		end
		r = $urandom_range(0, 3);
		if (r == 1) send_byte(CH_SPACE);
		else if (r == 2) send_byte(CH_COMMA);
		else if (r == 3) send_byte(CH_NL);
	endtask

	initial begin : main
		int pieces;
		int phase_no;
		int r;
		dir_rows[0]  = row(CH_COMMA, 1'b0, 1, tk(T_COMMA), NO_RES);
		dir_rows[1]  = row(CH_NL,    1'b0, 1, tk(T_NEWLINE), NO_RES);
		dir_rows[2]  = row(CH_OPEN,  1'b0, 1, tk(T_OPEN), NO_RES);
		dir_rows[3]  = row(CH_CLOSE, 1'b0, 1, tk(T_CLOSE), NO_RES);
		dir_rows[4]  = row(CH_MINUS, 1'b0, 1, tk(T_MINUS), NO_RES);
		dir_rows[5]  = row(CH_LA,    1'b0, 1, tx(T_SYMBOL, CH_LA), NO_RES);
		dir_rows[6]  = row(CH_COLON, 1'b0, 1, tk(T_LABEL), NO_RES);
		dir_rows[7]  = row(CH_DOT,   1'b0, 0, NO_RES, NO_RES);
		dir_rows[8]  = row(CH_UZ,    1'b0, 2, tx(T_SYMBOL, CH_DOT), tx(T_SYMBOL, CH_UZ));
		dir_rows[9]  = row(CH_UNDER, 1'b0, 1, tx(T_SYMBOL, CH_UNDER), NO_RES);
		dir_rows[10] = row(8'hFF,    1'b0, 1, tk(T_SYMBOL), NO_RES);
		dir_rows[11] = row(CH_ZERO,  1'b0, 0, NO_RES, NO_RES);
		dir_rows[12] = row(CH_X,     1'b0, 0, NO_RES, NO_RES);
		// hex prefix with no digits
		dir_rows[13] = row(CH_COMMA, 1'b0, 2, im(32'd0, 1'b1), tk(T_COMMA));
		dir_rows[14] = row(CH_ZERO,  1'b0, 0, NO_RES, NO_RES);
		dir_rows[15] = row(CH_SEVEN, 1'b0, 0, NO_RES, NO_RES);
		dir_rows[16] = row(CH_DOT,   1'b0, 1, im(32'd7, 1'b0), NO_RES);
		dir_rows[17] = row(CH_QUOTE, 1'b0, 1, tk(T_DOT), NO_RES);
		dir_rows[18] = row(8'h00,    1'b0, 1, tx(T_CHAR, 8'h00), NO_RES);
		dir_rows[19] = row(CH_QUOTE, 1'b0, 1, tk(T_CHAR), NO_RES);
		dir_rows[20] = row(CH_SEMI,  1'b0, 0, NO_RES, NO_RES);
		dir_rows[21] = row(8'hFF,    1'b0, 0, NO_RES, NO_RES);
		// end of text drops an open comment
		dir_rows[22] = row(8'hFF,    1'b1, 1, tk(T_END), NO_RES);
		dir_rows[23] = row(CH_NINE,  1'b0, -1, NO_RES, NO_RES);
		dir_rows[24] = row(8'h00,    1'b1, -1, NO_RES, NO_RES);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) drive_beat(dir_rows[i]);

		pieces = 0;
		phase_no = 0;
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		while (sent_beats < ITEM_TARGET) begin
			gen_piece();
			pieces++;
			if (pieces % 40 == 0) begin
				phase_no++;
				if (phase_no % 5 == 2) drain();
				r = $urandom_range(0, 3);
				gaps_on = r[0];
				stalls_on = r[1];
			end
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (plan_q.size() != 0 || token_expect_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### assembly_source_tokenizer.f
+incdir+hw/rtl
hw/rtl/ast_pkg.sv
hw/rtl/ast_lexer.sv
hw/rtl/assembly_source_tokenizer.sv
verif/tb.sv
